// File: rtl/itra_pkg.sv
package itra_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int STORE_DEPTH = VALUE_WIDTH;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int DIV_CNT_W = $clog2(VALUE_WIDTH + 1);

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [DIGIT_W-1:0] DECIMAL_BASE = 6'd10;

  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              negative;
    logic              is_last;
  } out_item_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     radix;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d >= DECIMAL_BASE) begin
      return CHAR_LOWER_A + dx - {1'b0, DECIMAL_BASE};
    end
    return CHAR_ZERO + dx;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

// File: rtl/integer_to_radix_ascii_core.sv
// Channel  Direction  Handshake        Payload
// in_      input      valid / stall    in_item_t  (value, is_signed)
// out_     output     valid / stall    out_item_t (digit_char, negative, is_last)
// cfg_     input      valid / ready    radix, 6 bits, clamped to 2..36
//
// One item at a time. Each digit costs one pass of the bit-serial divider, and
// each emitted digit is read from the digit store, loaded into the output
// register and held there until it is taken.
// rst_n is synchronous; the radix returns to 10. Input stalls from acceptance
// until the last digit of the run is taken; the digit register holds on stall.
module integer_to_radix_ascii_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  itra_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output itra_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data
);
  import itra_pkg::*;

  state_t state_r, state_nxt;

  logic [RADIX_W-1:0]     radix_r;
  logic [VALUE_WIDTH-1:0] quot_r;
  logic                   neg_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       rd_idx_r;
  out_item_t              out_r;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   in_xfer;
  logic                   out_xfer;
  logic                   last_digit;
  logic                   ram_we;
  logic                   ram_re;
  logic                   out_load;
  logic [DIGIT_W-1:0]     ram_rdata;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= clamp_radix(cfg_data);
    end
  end

  assign in_val = in_data.value[VALUE_WIDTH-1:0];
  assign in_neg = in_data.is_signed && in_val[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;

  assign in_xfer    = in_valid && !in_stall;
  assign out_xfer   = out_valid && !out_stall;
  assign last_digit = (div_rsp.quotient == '0) || (cnt_r == CNT_W'(STORE_DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = last_digit ? ST_EMIT_RD : ST_DIV_START;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_nxt = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (!out_stall) begin
          state_nxt = out_r.is_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall         = 1'b1;
    out_valid        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = quot_r;
    div_req.radix    = radix_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    out_load         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
      end
      ST_DIV_WAIT: begin
        ram_we = div_rsp.done;
      end
      ST_EMIT_RD: begin
        ram_re = 1'b1;
      end
      ST_EMIT_LD: begin
        out_load = 1'b1;
      end
      ST_EMIT_HOLD: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        cnt_r <= '0;
      end else if (ram_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      quot_r <= in_mag;
      neg_r  <= in_neg;
    end else if (ram_we) begin
      quot_r <= div_rsp.quotient;
    end
    // Start the readout at the most significant digit just stored.
    if (ram_we && last_digit) begin
      rd_idx_r <= cnt_r[IDX_W-1:0];
    end else if (out_xfer && !out_r.is_last) begin
      rd_idx_r <= rd_idx_r - IDX_W'(1);
    end
    if (out_load) begin
      out_r.digit_char <= digit_to_ascii(ram_rdata);
      out_r.negative   <= neg_r;
      out_r.is_last    <= (rd_idx_r == '0);
    end
  end

  assign out_data = out_r;

  itra_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  itra_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STORE_DEPTH)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (div_rsp.remainder),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/itra_ram.sv
module itra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/itra_divider.sv
module itra_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  itra_pkg::div_req_t req,
  output itra_pkg::div_rsp_t rsp
);
  import itra_pkg::*;

  logic [VALUE_WIDTH-1:0] quot_r, quot_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     radix_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;
  logic             fits;

  // One restoring shift-subtract step per cycle, dividend bits enter MSB first.
  always_comb begin
    trial    = {rem_r, quot_r[VALUE_WIDTH-1]};
    fits     = trial >= {1'b0, radix_r};
    diff     = trial - {1'b0, radix_r};
    rem_nxt  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    quot_nxt = {quot_r[VALUE_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(VALUE_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r  <= req.dividend;
      rem_r   <= '0;
      radix_r <= req.radix;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign rsp = {done_r, quot_r, rem_r};

endmodule

// File: tb/tb_integer_to_radix_ascii_core.sv
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii_core;
  import itra_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 15;

  typedef struct {
    bit                 wr_radix;
    logic [RADIX_W-1:0] radix_val;
    logic [63:0]        value;
    logic               is_signed;
    string              digits;
    logic               negative;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RADIX_W-1:0] cfg_data = '0;

  out_item_t pending_digits[$];
  logic [RADIX_W-1:0] radix_now = RADIX_RESET;
  logic hold_active = 1'b0;
  bit hold_req = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int digits_checked = 0;
  int radix_writes = 0;

  // empty digits string: expectation comes from the predictor
  dir_row_t dir_rows [22] = '{
    '{1'b0, 6'd0,  64'd0,                  1'b0, "0",                    1'b0},
    '{1'b0, 6'd0,  64'd12345,              1'b0, "12345",                1'b0},
    '{1'b0, 6'd0,  64'hffff_ffff_ffff_ffff, 1'b0, "18446744073709551615", 1'b0},
    '{1'b0, 6'd0,  64'hffff_ffff_ffff_ffff, 1'b1, "1",                    1'b1},
    '{1'b0, 6'd0,  64'h8000_0000_0000_0000, 1'b1, "9223372036854775808",  1'b1},
    '{1'b0, 6'd0,  64'h8000_0000_0000_0000, 1'b0, "9223372036854775808",  1'b0},
    '{1'b0, 6'd0,  64'h7fff_ffff_ffff_ffff, 1'b1, "9223372036854775807",  1'b0},
    '{1'b1, 6'd0,  64'd5,                  1'b0, "101",                  1'b0},
    '{1'b0, 6'd0,  64'hffff_ffff_ffff_ffff, 1'b0, "",                     1'b0},
    '{1'b0, 6'd0,  64'h8000_0000_0000_0000, 1'b1, "",                     1'b0},
    '{1'b1, 6'd1,  64'd0,                  1'b1, "0",                    1'b0},
    '{1'b1, 6'd37, 64'd35,                 1'b0, "z",                    1'b0},
    '{1'b0, 6'd0,  64'd36,                 1'b1, "10",                   1'b0},
    '{1'b0, 6'd0,  64'hffff_ffff_ffff_ffff, 1'b0, "",                     1'b0},
    '{1'b1, 6'd63, 64'hffff_ffff_ffff_fff6, 1'b1, "a",                    1'b1},
    '{1'b1, 6'd16, 64'hffff_ffff_ffff_ffff, 1'b0, "ffffffffffffffff",     1'b0},
    '{1'b0, 6'd0,  64'hdead_beef,           1'b1, "deadbeef",             1'b0},
    '{1'b1, 6'd36, 64'd10,                 1'b0, "a",                    1'b0},
    '{1'b1, 6'd2,  64'd1,                  1'b1, "1",                    1'b0},
    '{1'b1, 6'd8,  64'h0123_4567_89ab_cdef, 1'b0, "",                     1'b0},
    '{1'b1, 6'd10, 64'hffff_ffff_ffff_cfc7, 1'b1, "12345",                1'b1},
    '{1'b1, 6'd3,  64'h8000_0000_0000_0000, 1'b1, "",                     1'b0}
  };

  integer_to_radix_ascii_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [RADIX_W-1:0] saturate_radix(logic [RADIX_W-1:0] w);
    if (w < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (w > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return w;
  endfunction

  // Divide repeatedly, keep remainders, then queue them most significant first.
  function automatic void queue_expected_digits(logic [63:0] value, logic sgn);
    logic [63:0] mag;
    logic [63:0] base;
    logic [DIGIT_W-1:0] rems [64];
    logic neg;
    int n;
    out_item_t o;
    base = {{(64-RADIX_W){1'b0}}, radix_now};
    neg = sgn && value[63];
    mag = neg ? 64'd0 - value : value;
    n = 0;
    do begin
      rems[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < 64);
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] >= DECIMAL_BASE) begin
        o.digit_char = CHAR_LOWER_A + CHAR_W'(rems[k] - DECIMAL_BASE);
      end else begin
        o.digit_char = CHAR_ZERO + CHAR_W'(rems[k]);
      end
      o.negative = neg;
      o.is_last = (k == 0);
      pending_digits.push_back(o);
    end
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.value = {$urandom, $urandom};
    it.is_signed = 1'($urandom_range(0, 1));
    if (pick < 40) begin
      it.value = it.value >> $urandom_range(0, 63);
    end else if (pick < 55) begin
      it.value = 64'($urandom_range(0, 40));
    end else if (pick < 65) begin
      case ($urandom_range(0, 4))
        0: it.value = '0;
        1: it.value = '1;
        2: it.value = {1'b1, 63'd0};
        3: it.value = {1'b0, {63{1'b1}}};
        default: it.value = 64'd0 - 64'($urandom_range(1, 40));
      endcase
    end else if (pick < 75) begin
      it.value = 64'd0 - 64'($urandom_range(1, 5000));
      it.is_signed = 1'b1;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Drop valid and wait for the last digit, then let the core settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(logic [RADIX_W-1:0] w);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_now = saturate_radix(w);
    radix_writes++;
  endtask

  task automatic offer_item(in_item_t it, string typed_digits, logic typed_neg);
    out_item_t o;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (typed_digits.len() == 0) begin
      queue_expected_digits(it.value, it.is_signed);
    end else begin
      for (int i = 0; i < typed_digits.len(); i++) begin
        o.digit_char = CHAR_W'(typed_digits[i]);
        o.negative = typed_neg;
        o.is_last = (i == typed_digits.len() - 1);
        pending_digits.push_back(o);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit 0x%0h", out_data.digit_char));
      end else begin
        e = pending_digits.pop_front();
        digits_checked++;
        if (out_data.digit_char !== e.digit_char) begin
          report_mismatch($sformatf("digit_char 0x%0h, want 0x%0h",
                                    out_data.digit_char, e.digit_char));
        end
        if (out_data.negative !== e.negative) begin
          report_mismatch($sformatf("negative %b, want %b", out_data.negative, e.negative));
        end
        if (out_data.is_last !== e.is_last) begin
          report_mismatch($sformatf("is_last %b, want %b", out_data.is_last, e.is_last));
        end
      end
    end
    out_stall <= hold_active || (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
  end

  // Long output hold while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [RADIX_W-1:0] phase_radix [NUM_PHASES];
    in_item_t it;
    phase_radix = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd0, 6'd0, 6'd63, 6'd0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_radix) begin
        write_radix(dir_rows[i].radix_val);
      end
      it.value = dir_rows[i].value;
      it.is_signed = dir_rows[i].is_signed;
      offer_item(it, dir_rows[i].digits, dir_rows[i].negative);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 4 || p == 7) begin
        write_radix(RADIX_W'($urandom_range(0, 63)));
      end else begin
        write_radix(phase_radix[p]);
      end
      send_idle_pct = (p % 4 == 1) ? 52 : (p % 4 == 3) ? 36 : 0;
      stall_pct = (p % 4 == 2) ? 52 : (p % 4 == 3) ? 36 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == 4) begin
          hold_req = 1'b1;
        end
        if (p == 5 && n == 7) begin
          wait_idle();
        end
        offer_item(random_item(), "", 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d conversions and %0d digits across %0d radix writes",
             items_sent, digits_checked, radix_writes);
    $display({"directed extremes, then random phases with idle sender, stalled receiver, ",
              "and a long output hold"});
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
